[hw/rtl/assert_macros.svh]
// assertion macros for the tlsf index checker
// expects clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TLSF_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tlsf assertion failed");

// next-cycle implication, disabled during reset
`define TLSF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tlsf assertion failed");

`endif

[hw/rtl/tlsf_pkg.sv]
// shared types, codes and bit-search functions for the tlsf bucket index
// no dependencies
package tlsf_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NOFIT = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		logic load;
		logic round;
		logic map;
		logic exec;
		logic seek;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic need_seek;
	} dp_stat_t;

	function automatic logic [5:0] top_bit33(input logic [32:0] v);
		logic [5:0] n;
		n = '0;
		for (int i = 0; i < 33; i++) begin
			if (v[i]) n = 6'(i);
		end
		return n;
	endfunction

	function automatic logic [4:0] low_bit32(input logic [31:0] v);
		logic [4:0] n;
		n = '0;
		for (int i = 31; i >= 0; i--) begin
			if (v[i]) n = 5'(i);
		end
		return n;
	endfunction

endpackage

[hw/rtl/tlsf_if.sv]
// request and response channel interfaces of the tlsf bucket index
// depends on nothing
interface tlsf_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [31:0] size_bytes;

	modport source(output valid, op, size_bytes, input ready);
	modport sink(input valid, op, size_bytes, output ready);
endinterface

interface tlsf_rsp_if;
	logic       valid;
	logic       ready;
	logic [4:0] first_level;
	logic [4:0] second_level;
	logic [1:0] status;

	modport source(output valid, first_level, second_level, status, input ready);
	modport sink(input valid, first_level, second_level, status, output ready);
endinterface

[hw/rtl/tlsf_ctrl.sv]
// sequencing state machine of the tlsf bucket index
// depends on tlsf_pkg
module tlsf_ctrl import tlsf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_ROUND = 6'b000010,
		S_MAP   = 6'b000100,
		S_READ  = 6'b001000,
		S_SEEK  = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_ROUND;
				end
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				state_d   = S_MAP;
			end
			S_MAP: begin
				cmd.map = 1'b1;
				state_d = S_READ;
			end
			S_READ: begin
				cmd.exec = 1'b1;
				state_d  = stat.need_seek ? S_SEEK : S_EMIT;
			end
			S_SEEK: begin
				cmd.seek = 1'b1;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hw/rtl/tlsf_dp.sv]
// datapath of the tlsf bucket index: size mapping, bitmaps, count memory
// depends on tlsf_pkg
module tlsf_dp import tlsf_pkg::*; #(
	parameter int SL_SHIFT   = 5,
	parameter int FL_COUNT   = 32,
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	input  logic [1:0]  op,
	input  logic [31:0] size_bytes,
	output logic [4:0]  first_level,
	output logic [4:0]  second_level,
	output logic [1:0]  status
);

	localparam int SL    = 1 << SL_SHIFT;
	localparam int FLW   = $clog2(FL_COUNT);
	localparam int CAW   = FLW + SL_SHIFT;
	localparam int DEPTH = FL_COUNT * SL;

	op_t                  op_q;
	logic [31:0]          size_q;
	logic [32:0]          rnd_q;
	logic [5:0]           fl_q;
	logic [SL_SHIFT-1:0]  sl_q;
	logic [FL_COUNT-1:0]  class_q;
	logic [SL-1:0]        seg_mem [FL_COUNT];
	logic [COUNT_BITS-1:0] cnt_mem [DEPTH];
	logic [SL-1:0]        seg_rd_q;
	logic                 seg_ok_q;
	logic [COUNT_BITS-1:0] cnt_rd_q;
	logic [FLW-1:0]       up_fl_q;
	logic [4:0]           res_fl_q, res_sl_q;
	status_t              res_st_q;
	logic [4:0]           out_fl_q, out_sl_q;
	status_t              out_st_q;

	// rounding
	logic [5:0]  rnd_f, rnd_sh;
	logic [32:0] rnd_inc, rnd_d;

	always_comb begin
		rnd_f   = top_bit33({1'b0, size_q});
		rnd_sh  = rnd_f - 6'(SL_SHIFT);
		rnd_inc = (33'd1 << rnd_sh) - 33'd1;
		if (op_q == OP_SEARCH && size_q >= 32'(SL)) begin
			rnd_d = {1'b0, size_q} + rnd_inc;
		end else begin
			rnd_d = {1'b0, size_q};
		end
	end

	// bucket mapping
	logic                map_big;
	logic [5:0]          map_f, map_fl;
	logic [32:0]         map_t;
	logic [SL_SHIFT-1:0] map_sl;

	always_comb begin
		map_big = rnd_q >= 33'(SL);
		map_f   = top_bit33(rnd_q);
		map_t   = rnd_q >> (map_f - 6'(SL_SHIFT));
		if (map_big) begin
			map_fl = map_f;
			map_sl = map_t[SL_SHIFT-1:0];
		end else begin
			map_fl = '0;
			map_sl = rnd_q[SL_SHIFT-1:0];
		end
	end

	// read-modify-write of the selected bucket, and the search result
	logic [SL-1:0]         seg_w, sel, here, new_word;
	logic [FL_COUNT-1:0]   up;
	logic                  hit, oor, ins_ok, rem_ok, wr;
	logic [COUNT_BITS-1:0] cnt, cnt_inc, cnt_dec, new_cnt;
	logic [4:0]            here_lb, up_lb, seg_lb;
	logic [FLW-1:0]        seg_ra;
	logic [4:0]            ex_fl, ex_sl;
	status_t               ex_st;

	always_comb begin
		seg_w   = seg_ok_q ? seg_rd_q : '0;
		sel     = SL'(1) << sl_q;
		hit     = |(seg_w & sel);
		cnt     = hit ? cnt_rd_q : '0;
		oor     = fl_q >= 6'(FL_COUNT);
		for (int i = 0; i < SL; i++) begin
			here[i] = seg_w[i] && (SL_SHIFT'(i) >= sl_q);
		end
		for (int i = 0; i < FL_COUNT; i++) begin
			up[i] = class_q[i] && (6'(i) > fl_q);
		end
		here_lb = low_bit32(32'(here));
		up_lb   = low_bit32(32'(up));
		seg_lb  = low_bit32(32'(seg_w));
		cnt_inc = cnt + COUNT_BITS'(1);
		cnt_dec = cnt - COUNT_BITS'(1);
		ins_ok  = (op_q == OP_INSERT) && !oor && !(&cnt);
		rem_ok  = (op_q == OP_REMOVE) && !oor && (cnt != '0);
		new_cnt = ins_ok ? cnt_inc : cnt_dec;
		if (ins_ok) begin
			new_word = seg_w | sel;
		end else if (cnt_dec == '0) begin
			new_word = seg_w & ~sel;
		end else begin
			new_word = seg_w;
		end
		wr = cmd.exec && (ins_ok || rem_ok);
		stat.need_seek = (op_q == OP_SEARCH) && !oor && (here == '0) && (up != '0);
		seg_ra = cmd.exec ? FLW'(up_lb) : map_fl[FLW-1:0];

		ex_fl = fl_q[4:0];
		ex_sl = 5'(sl_q);
		ex_st = ST_OK;
		case (op_q)
			OP_SEARCH: begin
				if (oor || ((here == '0) && (up == '0))) begin
					ex_fl = '0;
					ex_sl = '0;
					ex_st = ST_NOFIT;
				end else begin
					ex_sl = here_lb;
				end
			end
			OP_INSERT: ex_st = ins_ok ? ST_OK : ST_FULL;
			OP_REMOVE: ex_st = rem_ok ? ST_OK : ST_EMPTY;
			default:   ex_st = ST_OK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op_t'(op);
			size_q <= size_bytes;
		end
		if (cmd.round) begin
			rnd_q <= rnd_d;
		end
		if (cmd.map) begin
			fl_q     <= map_fl;
			sl_q     <= map_sl;
			cnt_rd_q <= cnt_mem[{map_fl[FLW-1:0], map_sl}];
		end
		if (cmd.map || cmd.exec) begin
			seg_rd_q <= seg_mem[seg_ra];
			seg_ok_q <= class_q[seg_ra];
		end
		if (wr) begin
			seg_mem[fl_q[FLW-1:0]]          <= new_word;
			cnt_mem[CAW'({fl_q[FLW-1:0], sl_q})] <= new_cnt;
		end
		if (cmd.exec) begin
			up_fl_q  <= FLW'(up_lb);
			res_fl_q <= ex_fl;
			res_sl_q <= ex_sl;
			res_st_q <= ex_st;
		end
		if (cmd.seek) begin
			res_fl_q <= 5'(up_fl_q);
			res_sl_q <= seg_lb;
			res_st_q <= ST_OK;
		end
		if (cmd.emit) begin
			out_fl_q <= res_fl_q;
			out_sl_q <= res_sl_q;
			out_st_q <= res_st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_q <= '0;
		end else if (wr) begin
			class_q[fl_q[FLW-1:0]] <= |new_word;
		end
	end

	assign first_level  = out_fl_q;
	assign second_level = out_sl_q;
	assign status       = out_st_q;

endmodule

[hw/rtl/two_level_segregated_fit_index.sv]
// a request is accepted only in idle, then passes through the round, map, synchronous memory read
// and read-modify-write states, plus a seek state when a search moves to a higher class, and
// waits in emit while a held response is not taken; no new request is accepted until emit
// reset clears the class bitmap and control; segment and count memories are not swept,
// an entry counts as empty while its class or segment bit is clear
module two_level_segregated_fit_index import tlsf_pkg::*; #(
	parameter int SL_SHIFT   = 5,
	parameter int FL_COUNT   = 32,
	parameter int COUNT_BITS = 16
) (
	input logic          clk,
	input logic          arst_n,
	tlsf_req_if.sink     req,
	tlsf_rsp_if.source   rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	tlsf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	tlsf_dp #(
		.SL_SHIFT   (SL_SHIFT),
		.FL_COUNT   (FL_COUNT),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.op           (req.op),
		.size_bytes   (req.size_bytes),
		.first_level  (rsp.first_level),
		.second_level (rsp.second_level),
		.status       (rsp.status)
	);

endmodule

[hw/rtl/tlsf_chk.sv]
// port-level checker for the tlsf bucket index, bound to the top level
// depends on tlsf_pkg and assert_macros.svh
`include "assert_macros.svh"

module tlsf_chk import tlsf_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [4:0] first_level,
	input logic [4:0] second_level,
	input logic [1:0] status
);

	`TLSF_ASSERT(a_nofit_zero, rsp_valid && (status == ST_NOFIT), (first_level == 5'd0) && (second_level == 5'd0))
	`TLSF_ASSERT_NXT(a_one_at_a_time, req_valid && req_ready, !req_ready)
	`TLSF_ASSERT(a_no_early_word, $rose(rsp_valid), !$past(req_valid && req_ready))
	`TLSF_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(first_level) && $stable(second_level) && $stable(status))

endmodule

bind two_level_segregated_fit_index tlsf_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.first_level  (rsp.first_level),
	.second_level (rsp.second_level),
	.status       (rsp.status)
);
